[rtl/core/obb_pkg.sv]
`default_nettype none

package obb_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int CHUNK_BITS      = 3;

   typedef logic [2:0] code_type;

   localparam code_type SRC_VEC = 3'd0;
   localparam code_type SRC_DIF = 3'd1;
   localparam code_type SRC_CRS = 3'd2;
   localparam code_type SRC_TMP = 3'd3;
   localparam code_type SRC_EXT = 3'd4;

   localparam code_type ACC_NONE = 3'd0;
   localparam code_type ACC_P    = 3'd1;
   localparam code_type ACC_ADDP = 3'd2;
   localparam code_type ACC_SUBP = 3'd3;
   localparam code_type ACC_LD   = 3'd4;
   localparam code_type ACC_SUBB = 3'd5;

   localparam code_type PST_NONE  = 3'd0;
   localparam code_type PST_L     = 3'd1;
   localparam code_type PST_T     = 3'd2;
   localparam code_type PST_C     = 3'd3;
   localparam code_type PST_D     = 3'd4;
   localparam code_type PST_REXT  = 3'd5;
   localparam code_type PST_RZERO = 3'd6;
   localparam code_type PST_RADDP = 3'd7;

   typedef struct packed {
      code_type   kind;
      logic [2:0] slot;
      logic [1:0] comp;
   } src_type;

   typedef struct packed {
      logic                  xld;
      logic                  mul;
      logic                  mul_first;
      logic [CHUNK_BITS-1:0] chunk;
      code_type              acc;
      code_type              post;
      src_type               src;
   } cmd_type;

   typedef struct packed {
      logic sep;
   } stat_type;

   function automatic src_type mk_src(input code_type kind, input logic [2:0] slot,
                                      input logic [1:0] comp);
      src_type s;
      s.kind = kind;
      s.slot = slot;
      s.comp = comp;
      return s;
   endfunction

endpackage

`default_nettype wire

[rtl/core/obb_ctrl.sv]
`default_nettype none

module obb_ctrl import obb_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   input  wire logic     rsp_tready,
   output logic          req_ready,
   output logic          rsp_valid,
   output logic          rsp_overlap,
   output cmd_type       cmd
);

   localparam int NCH = (COORD_WIDTH + 8) / 8;
   localparam logic [4:0] FACE_LAST  = 5'd14;
   localparam logic [4:0] CROSS_LAST = 5'd24;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIFF = 3'd1;
   localparam logic [2:0] S_RUN  = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   function automatic logic [1:0] mod3(input logic [2:0] v);
      logic [2:0] r;
      r = (v < 3'd3) ? v : v - 3'd3;
      return r[1:0];
   endfunction

   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [3:0] phase_ff, phase_in;
   logic [1:0] ai_ff, ai_in, bj_ff, bj_in, k_ff, k_in;
   logic       kind_ff, kind_in, box_ff, box_in;
   logic       res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in, rsp_overlap_ff, rsp_overlap_in;

   logic [2:0] own_slot, oth_slot, own_ext, oth_ext;
   logic [4:0] ft, ct, cd;
   logic [1:0] cm, m1, m2, tt, ka, kb, q;
   logic [2:0] tslot, text;
   src_type    xs, ys, ps;
   code_type   aop, pop;
   logic       last;

   assign own_slot = (box_ff ? 3'd5 : 3'd1) + {1'b0, ai_ff};
   assign oth_slot = (box_ff ? 3'd1 : 3'd5) + {1'b0, ft[3:2]};
   assign own_ext  = (box_ff ? 3'd3 : 3'd0) + {1'b0, ai_ff};
   assign oth_ext  = (box_ff ? 3'd0 : 3'd3) + {1'b0, ft[3:2]};
   assign ft       = step_ff - 5'd3;
   assign ct       = step_ff - 5'd9;
   assign cd       = step_ff - 5'd6;
   assign cm       = step_ff[2:1];
   assign m1       = mod3({1'b0, cm} + 3'd1);
   assign m2       = mod3({1'b0, cm} + 3'd2);
   assign tt       = ct[3:2];
   assign q        = tt - 2'd2;
   assign ka       = (tt < ai_ff) ? tt : tt + 2'd1;
   assign kb       = (q < bj_ff) ? q : q + 2'd1;
   assign tslot    = tt[1] ? 3'd5 + {1'b0, kb} : 3'd1 + {1'b0, ka};
   assign text     = tt[1] ? 3'd3 + {1'b0, kb} : {1'b0, ka};

   always_comb begin
      xs   = mk_src(SRC_VEC, 3'd0, 2'd0);
      ys   = xs;
      ps   = xs;
      aop  = ACC_NONE;
      pop  = PST_NONE;
      last = 1'b0;
      if (!kind_ff) begin
         last = (step_ff == FACE_LAST);
         if (step_ff < 5'd3) begin
            xs  = mk_src(SRC_VEC, own_slot, step_ff[1:0]);
            ys  = mk_src(SRC_DIF, 3'd0, step_ff[1:0]);
            aop = (step_ff[1:0] == 2'd0) ? ACC_P : ACC_ADDP;
            if (step_ff[1:0] == 2'd0) begin
               pop = PST_REXT;
               ps  = mk_src(SRC_EXT, own_ext, 2'd0);
            end else if (step_ff[1:0] == 2'd2) begin
               pop = PST_L;
            end
         end else if (ft[1:0] != 2'd3) begin
            xs  = mk_src(SRC_VEC, own_slot, ft[1:0]);
            ys  = mk_src(SRC_VEC, oth_slot, ft[1:0]);
            aop = (ft[1:0] == 2'd0) ? ACC_P : ACC_ADDP;
            if (ft[1:0] == 2'd2) begin
               pop = PST_T;
            end
         end else begin
            xs  = mk_src(SRC_TMP, 3'd0, 2'd0);
            ys  = mk_src(SRC_EXT, oth_ext, 2'd0);
            pop = PST_RADDP;
         end
      end else begin
         last = (step_ff == CROSS_LAST);
         if (step_ff < 5'd6) begin
            xs  = mk_src(SRC_VEC, 3'd1 + {1'b0, ai_ff}, step_ff[0] ? m2 : m1);
            ys  = mk_src(SRC_VEC, 3'd5 + {1'b0, bj_ff}, step_ff[0] ? m1 : m2);
            aop = step_ff[0] ? ACC_SUBP : ACC_P;
            if (step_ff[0]) begin
               pop = PST_C;
               ps  = mk_src(SRC_CRS, 3'd0, cm);
            end else if (step_ff == 5'd0) begin
               pop = PST_RZERO;
            end
         end else if (step_ff < 5'd9) begin
            xs  = mk_src(SRC_CRS, 3'd0, cd[1:0]);
            ys  = mk_src(SRC_DIF, 3'd0, cd[1:0]);
            aop = (cd[1:0] == 2'd0) ? ACC_P : ACC_ADDP;
            if (cd[1:0] == 2'd2) begin
               pop = PST_L;
            end
         end else if (ct[1:0] != 2'd3) begin
            xs  = mk_src(SRC_CRS, 3'd0, ct[1:0]);
            ys  = mk_src(SRC_VEC, tslot, ct[1:0]);
            aop = (ct[1:0] == 2'd0) ? ACC_P : ACC_ADDP;
            if (ct[1:0] == 2'd2) begin
               pop = PST_T;
            end
         end else begin
            xs  = mk_src(SRC_TMP, 3'd0, 2'd0);
            ys  = mk_src(SRC_EXT, text, 2'd0);
            pop = PST_RADDP;
         end
      end
   end

   always_comb begin
      cmd = '0;
      cmd.src = xs;
      if (state_ff == S_RUN) begin
         if (phase_ff == 4'd0) begin
            cmd.xld = 1'b1;
         end else if (phase_ff <= 4'(NCH)) begin
            cmd.mul       = 1'b1;
            cmd.mul_first = (phase_ff == 4'd1);
            cmd.chunk     = CHUNK_BITS'(NCH) - CHUNK_BITS'(phase_ff);
            cmd.src       = ys;
         end else if (phase_ff == 4'(NCH + 1)) begin
            cmd.acc = aop;
         end else begin
            cmd.post = pop;
            cmd.src  = ps;
         end
      end else if (state_ff == S_DIFF) begin
         if (phase_ff == 4'd0) begin
            cmd.acc = ACC_LD;
            cmd.src = mk_src(SRC_VEC, 3'd0, k_ff);
         end else if (phase_ff == 4'd1) begin
            cmd.acc = ACC_SUBB;
            cmd.src = mk_src(SRC_VEC, 3'd4, k_ff);
         end else begin
            cmd.post = PST_D;
            cmd.src  = mk_src(SRC_DIF, 3'd0, k_ff);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      phase_in       = phase_ff;
      ai_in          = ai_ff;
      bj_in          = bj_ff;
      k_in           = k_ff;
      kind_in        = kind_ff;
      box_in         = box_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_overlap_in = rsp_overlap_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DIFF;
               k_in     = 2'd0;
               phase_in = 4'd0;
            end
         end
         S_DIFF: begin
            if (phase_ff == 4'd2) begin
               phase_in = 4'd0;
               k_in     = k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  state_in = S_RUN;
                  kind_in  = 1'b0;
                  box_in   = 1'b0;
                  ai_in    = 2'd0;
                  bj_in    = 2'd0;
                  step_in  = 5'd0;
               end
            end else begin
               phase_in = phase_ff + 4'd1;
            end
         end
         S_RUN: begin
            if (phase_ff == 4'(NCH + 2)) begin
               phase_in = 4'd0;
               if (last) begin
                  state_in = S_CHK;
               end else begin
                  step_in = step_ff + 5'd1;
               end
            end else begin
               phase_in = phase_ff + 4'd1;
            end
         end
         S_CHK: begin
            step_in  = 5'd0;
            state_in = S_RUN;
            if (stat.sep) begin
               res_in   = 1'b0;
               state_in = S_FIN;
            end else if (!kind_ff) begin
               if (ai_ff != 2'd2) begin
                  ai_in = ai_ff + 2'd1;
               end else if (!box_ff) begin
                  box_in = 1'b1;
                  ai_in  = 2'd0;
               end else begin
                  kind_in = 1'b1;
                  ai_in   = 2'd0;
                  bj_in   = 2'd0;
               end
            end else if (bj_ff != 2'd2) begin
               bj_in = bj_ff + 2'd1;
            end else if (ai_ff != 2'd2) begin
               ai_in = ai_ff + 2'd1;
               bj_in = 2'd0;
            end else begin
               res_in   = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_overlap_in = res_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff        <= step_in;
      phase_ff       <= phase_in;
      ai_ff          <= ai_in;
      bj_ff          <= bj_in;
      k_ff           <= k_in;
      kind_ff        <= kind_in;
      box_ff         <= box_in;
      res_ff         <= res_in;
      rsp_overlap_ff <= rsp_overlap_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

endmodule

`default_nettype wire

[rtl/core/obb_dpath.sv]
`default_nettype none

module obb_dpath import obb_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [2:0]                    wr_slot,
   input  wire logic signed [COORD_WIDTH-1:0] wr_x,
   input  wire logic signed [COORD_WIDTH-1:0] wr_y,
   input  wire logic signed [COORD_WIDTH-1:0] wr_z,
   input  wire logic [COORD_WIDTH-2:0]        wr_ext,
   input  wire cmd_type                       cmd,
   output stat_type                           stat
);

   localparam int W = 4 * COORD_WIDTH + 4;

   logic [COORD_WIDTH-1:0] vec_ff [8][3];
   logic [COORD_WIDTH-2:0] ext_ff [6];
   logic [2:0]             ext_idx;

   logic signed [W-1:0] x_ff, p_ff, acc_ff, t_ff, l_ff, r_ff;
   logic signed [W-1:0] d_ff [3];
   logic signed [W-1:0] c_ff [3];
   logic signed [W-1:0] bus, acc_abs;
   logic signed [8:0]   ch;
   logic signed [W+8:0] prod;
   logic [7:0]          ch_byte;

   assign ext_idx = wr_slot[2] ? {1'b0, wr_slot[1:0]} + 3'd2 : {1'b0, wr_slot[1:0]} - 3'd1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vec_ff[wr_slot][0] <= wr_x;
         vec_ff[wr_slot][1] <= wr_y;
         vec_ff[wr_slot][2] <= wr_z;
         if (wr_slot[1:0] != 2'd0) begin
            ext_ff[ext_idx] <= wr_ext;
         end
      end
   end

   always_comb begin
      unique case (cmd.src.kind)
         SRC_VEC: bus = W'($signed(vec_ff[cmd.src.slot][cmd.src.comp]));
         SRC_DIF: bus = d_ff[cmd.src.comp];
         SRC_CRS: bus = c_ff[cmd.src.comp];
         SRC_TMP: bus = t_ff;
         SRC_EXT: bus = W'($signed({1'b0, ext_ff[cmd.src.slot]}));
         default: bus = '0;
      endcase
   end

   assign ch_byte = bus[8*cmd.chunk +: 8];
   assign ch      = cmd.mul_first ? $signed({ch_byte[7], ch_byte}) : $signed({1'b0, ch_byte});
   assign prod    = x_ff * ch;
   assign acc_abs = acc_ff[W-1] ? -acc_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.xld) begin
         x_ff <= bus;
      end
      if (cmd.mul) begin
         p_ff <= cmd.mul_first ? prod[W-1:0] : (p_ff <<< 8) + prod[W-1:0];
      end
      case (cmd.acc)
         ACC_P:    acc_ff <= p_ff;
         ACC_ADDP: acc_ff <= acc_ff + p_ff;
         ACC_SUBP: acc_ff <= acc_ff - p_ff;
         ACC_LD:   acc_ff <= bus;
         ACC_SUBB: acc_ff <= acc_ff - bus;
         default:  acc_ff <= acc_ff;
      endcase
      case (cmd.post)
         PST_L:     l_ff <= acc_abs <<< FRAC_BITS;
         PST_T:     t_ff <= acc_abs;
         PST_C:     c_ff[cmd.src.comp] <= acc_ff;
         PST_D:     d_ff[cmd.src.comp] <= acc_ff;
         PST_REXT:  r_ff <= bus <<< (2 * FRAC_BITS);
         PST_RZERO: r_ff <= '0;
         PST_RADDP: r_ff <= r_ff + p_ff;
         default:   t_ff <= t_ff;
      endcase
   end

   assign stat.sep = (l_ff > r_ff);

endmodule

`default_nettype wire

[rtl/core/obb_overlap_test.sv]
// Load: one word per cycle while idle (req_tready high); a word without the evaluate flag is just stored.
// Evaluate: the 6 face axes and 9 cross axes are tested in turn by one shared serial
// multiplier taking 8 bits of the short operand per cycle, N = (COORD_WIDTH+8)/8 chunks;
// the test ends early when an axis separates the boxes.
// Reset: synchronous, active high; clears control and the result valid, stores keep
// their contents and are undefined until written.
`default_nettype none

module obb_overlap_test import obb_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // vector_slot, comp_x, comp_y, comp_z, half_extent, evaluate, zero fill
   input  wire logic [((4*COORD_WIDTH+3+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // overlap, zero fill
   output logic [7:0] rsp_tdata
);

   localparam int CW    = COORD_WIDTH;
   localparam int EV_AT = 4 * CW + 2;

   logic     accept, overlap;
   cmd_type  cmd;
   stat_type stat;

   assign accept = req_tvalid && req_tready;

   obb_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (accept && req_tdata[EV_AT]),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .req_ready   (req_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_overlap (overlap),
      .cmd         (cmd)
   );

   obb_dpath #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dpath (
      .clock   (clock),
      .wr_en   (accept),
      .wr_slot (req_tdata[2:0]),
      .wr_x    (req_tdata[3 +: CW]),
      .wr_y    (req_tdata[3+CW +: CW]),
      .wr_z    (req_tdata[3+2*CW +: CW]),
      .wr_ext  (req_tdata[3+3*CW +: CW-1]),
      .cmd     (cmd),
      .stat    (stat)
   );

   assign rsp_tdata = {7'd0, overlap};

   a_busy_after_eval: assert property (@(posedge clock) disable iff (reset)
      accept && req_tdata[EV_AT] |=> !req_tready)
      else $error("input taken while a test runs");

   a_result_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result without a test run");

endmodule

`default_nettype wire
